// ===== hdl/bitmap_run_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap run allocator assertion macros
// shorthand for clocked assertions on clk with arst_n as the disable
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// field widths, codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int FUNC_W        = 2;
	localparam int INDEX_W       = 21;
	localparam int COUNT_W       = 11;
	localparam int BASE_W        = 20;
	localparam int LEN_W         = 8;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 20;
	localparam int BIT_SEL_W     = 3;
	localparam int DEF_MAP_BYTES = 128;

	localparam logic [LEN_W-1:0]     LEN_RESET = 8'd128;
	localparam logic [BIT_SEL_W-1:0] BIT_MAX   = 3'd7;

	typedef enum logic [FUNC_W-1:0] {
		FN_TEST  = 2'd0,
		FN_SET   = 2'd1,
		FN_CLEAR = 2'd2,
		FN_ALLOC = 2'd3
	} fn_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_INDEX   = 1'b0,
		REG_LENGTH_BYTES = 1'b1
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic req_load;
		logic decode;
		logic clr_wr;
		logic bit_exec;
		logic scan_step;
		logic mark_step;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic skip_alloc;
		logic range_err;
		logic scan_hit;
		logic scan_last;
		logic mark_last;
		logic clr_last;
	} dp_sts_t;

endpackage

// ===== hdl/bra_if.sv =====
// ----------------------------------------------------------------------------
// bra channel interfaces
// request, response and configuration write channels
// ----------------------------------------------------------------------------
interface bra_req_if import bra_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [INDEX_W-1:0] index;
	logic [COUNT_W-1:0] count;

	modport source (output valid, func, index, count, input ready);
	modport sink (input valid, func, index, count, output ready);
endinterface

interface bra_rsp_if import bra_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               bit_value;
	logic [INDEX_W-1:0] start_index;
	logic               found;
	logic               range_error;

	modport source (output valid, bit_value, start_index, found, range_error, input ready);
	modport sink (input valid, bit_value, start_index, found, range_error, output ready);
endinterface

interface bra_cfg_if import bra_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bra_ram.sv =====
// ----------------------------------------------------------------------------
// bra_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/bra_datapath.sv =====
// ----------------------------------------------------------------------------
// bra_datapath
// config and request registers, bitmap ram, run scan and run marking
// ----------------------------------------------------------------------------
module bra_datapath import bra_pkg::*; #(
	parameter int MAP_BYTES = DEF_MAP_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [FUNC_W-1:0]     req_func,
	input  logic [INDEX_W-1:0]    req_index,
	input  logic [COUNT_W-1:0]    req_count,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic                  bit_value,
	output logic [INDEX_W-1:0]    start_index,
	output logic                  found,
	output logic                  range_error
);

	localparam int AW    = MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1;
	localparam int BW    = AW + BIT_SEL_W;
	localparam int EXT_W = (BW > COUNT_W ? BW : COUNT_W) + 1;
	localparam int CMP_W = (AW > LEN_W ? AW : LEN_W) + 1;

	// configuration
	logic [BASE_W-1:0] base_q;
	logic [LEN_W-1:0]  length_q;

	// request
	fn_t                func_q;
	logic [INDEX_W-1:0] index_q;
	logic [COUNT_W-1:0] count_q;

	// scan and mark
	logic [AW-1:0]        pk_q;
	logic [AW-1:0]        mk_q;
	logic [COUNT_W-1:0]   run_q;
	logic [AW-1:0]        first_byte_q;
	logic [BIT_SEL_W-1:0] first_bit_q;
	logic [AW-1:0]        last_byte_q;
	logic [BIT_SEL_W-1:0] last_bit_q;
	logic [AW-1:0]        clr_q;

	// result and output registers
	logic               bit_q;
	logic [INDEX_W-1:0] start_q;
	logic               found_q;
	logic               err_q;
	logic               out_bit_q;
	logic [INDEX_W-1:0] out_start_q;
	logic               out_found_q;
	logic               out_err_q;

	// ram
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// combinational
	logic [LEN_W-1:0]     win;
	logic [INDEX_W-1:0]   rel;
	logic                 range_err;
	logic [AW-1:0]        rel_byte;
	logic [BIT_SEL_W-1:0] rel_bit;
	logic [7:0]           bit_mask;
	logic [COUNT_W-1:0]   run_next;
	logic                 hit;
	logic [BIT_SEL_W-1:0] hit_bit;
	logic [BW-1:0]        pos;
	logic [EXT_W-1:0]     first_ext;
	logic [BW-1:0]        first;
	logic [BIT_SEL_W-1:0] mark_lo;
	logic [BIT_SEL_W-1:0] mark_hi;
	logic [7:0]           mark_mask;

	bra_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// window limited to the store size
	assign win = (32'(length_q) < MAP_BYTES) ? length_q : LEN_W'(MAP_BYTES);

	assign rel       = index_q - INDEX_W'(base_q);
	assign range_err = (index_q < INDEX_W'(base_q))
		|| (rel[INDEX_W-1:BIT_SEL_W] >= (INDEX_W-BIT_SEL_W)'(win));
	assign rel_byte  = rel[AW+BIT_SEL_W-1:BIT_SEL_W];
	assign rel_bit   = rel[BIT_SEL_W-1:0];
	assign bit_mask  = 8'b1 << rel_bit;

	// run counter over the eight bits of the current byte
	always_comb begin
		logic [COUNT_W-1:0] run_v;
		logic               hit_v;
		logic [BIT_SEL_W-1:0] hb_v;
		run_v = run_q;
		hit_v = 1'b0;
		hb_v  = '0;
		for (int b = 0; b < 8; b++) begin
			if (!hit_v) begin
				run_v = ram_rdata[b] ? '0 : run_v + 1'b1;
				if (run_v == count_q) begin
					hit_v = 1'b1;
					hb_v  = BIT_SEL_W'(b);
				end
			end
		end
		run_next = run_v;
		hit      = hit_v;
		hit_bit  = hb_v;
	end

	assign pos       = {pk_q, hit_bit};
	assign first_ext = EXT_W'(pos) + 1'b1 - EXT_W'(count_q);
	assign first     = first_ext[BW-1:0];

	assign mark_lo = (mk_q == first_byte_q) ? first_bit_q : '0;
	assign mark_hi = (mk_q == last_byte_q) ? last_bit_q : BIT_MAX;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mark_mask[b] = (BIT_SEL_W'(b) >= mark_lo) && (BIT_SEL_W'(b) <= mark_hi);
		end
	end

	// ram port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		priority if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (cmd.decode) begin
			ram_raddr = (func_q == FN_ALLOC) ? '0 : rel_byte;
		end else if (cmd.bit_exec) begin
			ram_we    = (func_q != FN_TEST);
			ram_waddr = rel_byte;
			ram_wdata = (func_q == FN_SET) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
		end else if (cmd.scan_step) begin
			ram_raddr = hit ? first[BW-1:BIT_SEL_W] : pk_q + 1'b1;
		end else if (cmd.mark_step) begin
			ram_we    = 1'b1;
			ram_waddr = mk_q;
			ram_wdata = ram_rdata | mark_mask;
			ram_raddr = mk_q + 1'b1;
		end
	end

	assign sts.is_alloc   = (func_q == FN_ALLOC);
	assign sts.skip_alloc = (count_q == '0) || (win == '0);
	assign sts.range_err  = range_err;
	assign sts.scan_hit   = hit;
	assign sts.scan_last  = (CMP_W'(pk_q) + 1'b1) == CMP_W'(win);
	assign sts.mark_last  = (mk_q == last_byte_q);
	assign sts.clr_last   = (clr_q == AW'(MAP_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			length_q <= LEN_RESET;
			clr_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_BASE_INDEX:   base_q   <= cfg_data[BASE_W-1:0];
					REG_LENGTH_BYTES: length_q <= cfg_data[LEN_W-1:0];
				endcase
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			func_q  <= fn_t'(req_func);
			index_q <= req_index;
			count_q <= req_count;
			bit_q   <= 1'b0;
			start_q <= '0;
			found_q <= 1'b0;
			err_q   <= 1'b0;
		end
		if (cmd.decode) begin
			err_q <= (func_q != FN_ALLOC) && range_err;
			pk_q  <= '0;
			run_q <= '0;
		end
		if (cmd.bit_exec && func_q == FN_TEST) begin
			bit_q <= ram_rdata[rel_bit];
		end
		if (cmd.scan_step) begin
			if (hit) begin
				found_q      <= 1'b1;
				start_q      <= INDEX_W'(base_q) + INDEX_W'(first);
				first_byte_q <= first[BW-1:BIT_SEL_W];
				first_bit_q  <= first[BIT_SEL_W-1:0];
				last_byte_q  <= pk_q;
				last_bit_q   <= hit_bit;
				mk_q         <= first[BW-1:BIT_SEL_W];
			end else begin
				pk_q  <= pk_q + 1'b1;
				run_q <= run_next;
			end
		end
		if (cmd.mark_step) begin
			mk_q <= mk_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_bit_q   <= bit_q;
			out_start_q <= start_q;
			out_found_q <= found_q;
			out_err_q   <= err_q;
		end
	end

	assign bit_value   = out_bit_q;
	assign start_index = out_start_q;
	assign found       = out_found_q;
	assign range_error = out_err_q;

endmodule

// ===== hdl/bra_ctrl.sv =====
// ----------------------------------------------------------------------------
// bra_ctrl
// sequencer for clearing, bit operations, run scan and run marking
// ----------------------------------------------------------------------------
module bra_ctrl import bra_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_BITOP,
		ST_SCAN,
		ST_MARK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   rsp_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clr_wr    = 1'b1;
			ST_IDLE:   cmd.req_load  = req_valid && ready_q;
			ST_DECODE: cmd.decode    = 1'b1;
			ST_BITOP:  cmd.bit_exec  = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_MARK:   cmd.mark_step = 1'b1;
			ST_FINISH: cmd.out_load  = !rsp_valid_q || rsp_ready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ready_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.req_load) begin
						state_q <= ST_DECODE;
						ready_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					if (sts.is_alloc) begin
						state_q <= sts.skip_alloc ? ST_FINISH : ST_SCAN;
					end else begin
						state_q <= sts.range_err ? ST_FINISH : ST_BITOP;
					end
				end
				ST_BITOP: state_q <= ST_FINISH;
				ST_SCAN: begin
					// a hit on the last byte still wins
					if (sts.scan_hit) begin
						state_q <= ST_MARK;
					end else if (sts.scan_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_MARK: begin
					if (sts.mark_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
			endcase
		end
	end

	assign req_ready = ready_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hdl/bitmap_run_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit page bitmap allocator. The bitmap sits in a MAP_BYTES x 8 ram
// with one registered read port, so the block works on one request at a
// time and the ram port sets the pace. Test, set and clear pass through
// decode and a bit operation before the response register loads; an
// out-of-range index skips the bit operation. Allocate decodes, scans the
// bitmap byte by byte up to and including the byte that completes the run
// (or the last window byte), marks each byte the run touches and loads
// the response; with a zero count or an empty window it goes from decode
// straight to the response. The next request is taken in the cycle after
// the response register loads, and a finished response waits in that
// register while the next request is taken; a response that is still
// waiting when the following one is done holds the block until it leaves.
// After reset the bitmap is cleared one byte per cycle and requests are
// held off until that ends; configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`include "bitmap_run_allocator_macros.svh"

module bitmap_run_allocator import bra_pkg::*; #(
	parameter int MAP_BYTES = DEF_MAP_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	bra_req_if.sink   req,
	bra_rsp_if.source rsp,
	bra_cfg_if.sink   cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	bra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bra_datapath #(
		.MAP_BYTES (MAP_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.req_func    (req.func),
		.req_index   (req.index),
		.req_count   (req.count),
		.cmd         (cmd),
		.sts         (sts),
		.bit_value   (rsp.bit_value),
		.start_index (rsp.start_index),
		.found       (rsp.found),
		.range_error (rsp.range_error)
	);

	// no bitmap write while waiting for a request
	`BRA_ASSERT_IMP(a_idle_no_write, req.ready, !(cmd.clr_wr || cmd.bit_exec || cmd.mark_step), "bitmap written while idle")
	// one request at a time
	`BRA_ASSERT_NXT(a_busy_after_req, req.valid && req.ready, !req.ready, "request taken while busy")
	`BRA_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0({cmd.req_load, cmd.decode, cmd.clr_wr, cmd.bit_exec, cmd.scan_step, cmd.mark_step, cmd.out_load}), "more than one datapath command")
	`BRA_ASSERT_IMP(a_found_no_err, rsp.valid, !(rsp.found && rsp.range_error), "found and range error together")

endmodule
